// ===== sv/pfc_pkg.sv =====
// shared types, constants and helper functions for the playfair digram cipher
package pfc_pkg;

    localparam int LETTER_W   = 5;
    localparam int SIDE       = 5;
    localparam int CELLS      = SIDE * SIDE;
    localparam int POS_W      = 3;
    localparam int CELL_IDX_W = $clog2(CELLS);
    localparam int CFG_W      = 60;
    localparam int LOW_CELLS  = 12;
    localparam int DATA_W     = 8;

    localparam logic [LETTER_W-1:0] PAD_CODE  = LETTER_W'(23);
    localparam logic [LETTER_W-1:0] FOLD_FROM = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] FOLD_TO   = LETTER_W'(8);
    localparam logic [POS_W-1:0]    LAST_POS  = POS_W'(SIDE - 1);

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [POS_W-1:0]    pos_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_DIRECTION   = 2'd0,
        REG_CELLS_LOW   = 2'd1,
        REG_CELLS_MID   = 2'd2,
        REG_CELL_LAST   = 2'd3
    } reg_index_t;

    // key square and direction as seen by the back end
    typedef struct packed {
        logic                   direction;
        letter_t [CELLS-1:0]    cells;
    } cfg_t;

    // one digram job passed from front to back
    typedef struct packed {
        letter_t a;
        letter_t b;
        logic    run_last;
        logic    msg_end;
    } digram_t;

    // one result beat
    typedef struct packed {
        letter_t letter;
        logic    run_last;
        logic    msg_end;
    } beat_t;

    typedef struct packed {
        pos_t row;
        pos_t col;
    } loc_t;

    // j folds onto i
    function automatic letter_t fold(input letter_t l);
        fold = (l == FOLD_FROM) ? FOLD_TO : l;
    endfunction

    // wrapping step, forward for encrypt and backward for decrypt
    function automatic pos_t step_pos(input pos_t p, input logic dir);
        if (dir) begin
            step_pos = (p == '0) ? LAST_POS : POS_W'(p - POS_W'(1));
        end else begin
            step_pos = (p == LAST_POS) ? '0 : POS_W'(p + POS_W'(1));
        end
    endfunction

    // first matching cell in row-major order, row 0 column 0 when absent
    function automatic loc_t locate(input letter_t [CELLS-1:0] cells, input letter_t l);
        loc_t res;
        res = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (cells[r * SIDE + c] == l) begin
                    res.row = POS_W'(r);
                    res.col = POS_W'(c);
                end
            end
        end
        locate = res;
    endfunction

    // cell read at a row and column
    function automatic letter_t cell_at(input letter_t [CELLS-1:0] cells,
                                        input pos_t r, input pos_t c);
        logic [CELL_IDX_W-1:0] idx;
        idx = {r[CELL_IDX_W-3:0], 2'b00} + CELL_IDX_W'(r) + CELL_IDX_W'(c);
        cell_at = cells[idx];
    endfunction

endpackage

// ===== sv/pfc_front.sv =====
// front end: pairs letters into digrams and inserts pads
module pfc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfc_pkg::letter_t   in_letter,
    input  logic               in_last,
    output logic               push,
    output pfc_pkg::digram_t   push_data,
    input  logic               q_full
);
    import pfc_pkg::*;

    letter_t  held_letter_reg, held_letter_next;
    logic     held_valid_reg,  held_valid_next;
    logic     pend_valid_reg,  pend_valid_next;
    digram_t  pend_reg,        pend_next;

    logic     in_accept;
    logic     gen;
    digram_t  gen_data;

    // a pending second digram blocks new letters
    assign in_ready  = !pend_valid_reg && !q_full;
    assign in_accept = in_valid && in_ready;

    // classify the incoming letter
    always_comb begin
        gen              = 1'b0;
        gen_data         = '0;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        if (pend_valid_reg && !q_full) begin
            pend_valid_next = 1'b0;
        end
        if (in_accept) begin
            if (held_valid_reg && (held_letter_reg != in_letter)) begin
                gen             = 1'b1;
                gen_data        = '{a: held_letter_reg, b: in_letter,
                                    run_last: 1'b1, msg_end: in_last};
                held_valid_next = 1'b0;
            end else if (held_valid_reg) begin
                // doubled letter: split with a pad
                gen = 1'b1;
                if (in_last) begin
                    gen_data        = '{a: held_letter_reg, b: PAD_CODE,
                                        run_last: 1'b0, msg_end: 1'b0};
                    pend_valid_next = 1'b1;
                    pend_next       = '{a: in_letter, b: PAD_CODE,
                                        run_last: 1'b1, msg_end: 1'b1};
                    held_valid_next = 1'b0;
                end else begin
                    gen_data        = '{a: held_letter_reg, b: PAD_CODE,
                                        run_last: 1'b1, msg_end: 1'b0};
                    held_letter_next = in_letter;
                end
            end else if (in_last) begin
                // lone final letter
                gen      = 1'b1;
                gen_data = '{a: in_letter, b: PAD_CODE, run_last: 1'b1, msg_end: 1'b1};
                held_letter_next = in_letter;
            end else begin
                held_letter_next = in_letter;
                held_valid_next  = 1'b1;
            end
        end
    end

    // queue write, pending digram first
    assign push      = pend_valid_reg ? !q_full : gen;
    assign push_data = pend_valid_reg ? pend_reg : gen_data;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end else begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    // pending digram payload
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    a_pend_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> !held_valid_reg)
        else $error("pending digram while a letter is held");

    a_pend_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> !in_ready)
        else $error("input taken while a digram is pending");

    a_last_flushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_last) |=> !held_valid_reg)
        else $error("letter still held after end of message");

endmodule

// ===== sv/pfc_queue.sv =====
// two-entry digram queue between front and back
module pfc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pfc_pkg::digram_t   push_data,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output pfc_pkg::digram_t   data
);
    import pfc_pkg::*;

    digram_t     slot_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic        do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign data    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and count update
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // slot write
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("digram pushed into a full queue");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        ((count_reg == 2'd0) || (count_reg == 2'd2)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== sv/pfc_back.sv =====
// back end: key square lookup and two-beat result output
module pfc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  pfc_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  pfc_pkg::digram_t   q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output pfc_pkg::beat_t     m_beat
);
    import pfc_pkg::*;

    logic   m_valid_reg,   m_valid_next;
    logic   sec_valid_reg, sec_valid_next;
    beat_t  m_beat_reg,    m_beat_next;
    beat_t  sec_beat_reg,  sec_beat_next;

    loc_t     loc_a, loc_b;
    pos_t     ra, ca, rb, cb;
    letter_t  out_a, out_b;
    logic     load_ok;

    // locate both letters and apply the row, column or rectangle rule
    always_comb begin
        loc_a = locate(cfg.cells, fold(q_data.a));
        loc_b = locate(cfg.cells, fold(q_data.b));
        if (loc_a.row == loc_b.row) begin
            ra = loc_a.row;
            rb = loc_b.row;
            ca = step_pos(loc_a.col, cfg.direction);
            cb = step_pos(loc_b.col, cfg.direction);
        end else if (loc_a.col == loc_b.col) begin
            ra = step_pos(loc_a.row, cfg.direction);
            rb = step_pos(loc_b.row, cfg.direction);
            ca = loc_a.col;
            cb = loc_b.col;
        end else begin
            ra = loc_a.row;
            ca = loc_b.col;
            rb = loc_b.row;
            cb = loc_a.col;
        end
        out_a = cell_at(cfg.cells, ra, ca);
        out_b = cell_at(cfg.cells, rb, cb);
    end

    // output register plus one waiting second letter
    assign load_ok = !m_valid_reg || m_ready;
    assign q_pop   = q_valid && !sec_valid_reg && load_ok;

    always_comb begin
        m_valid_next   = m_valid_reg;
        sec_valid_next = sec_valid_reg;
        m_beat_next    = m_beat_reg;
        sec_beat_next  = sec_beat_reg;
        priority if (sec_valid_reg && load_ok) begin
            m_beat_next    = sec_beat_reg;
            m_valid_next   = 1'b1;
            sec_valid_next = 1'b0;
        end else if (q_pop) begin
            m_beat_next    = '{letter: out_a, run_last: 1'b0, msg_end: 1'b0};
            sec_beat_next  = '{letter: out_b, run_last: q_data.run_last,
                              msg_end: q_data.msg_end};
            m_valid_next   = 1'b1;
            sec_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else begin
            m_valid_reg   <= m_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_beat_reg   <= m_beat_next;
        sec_beat_reg <= sec_beat_next;
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    a_sec_behind_first: assert property (@(posedge aclk) disable iff (!aresetn)
        sec_valid_reg |-> m_valid_reg)
        else $error("second letter waiting with no first letter shown");

    a_pop_loads_both: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (m_valid_reg && sec_valid_reg))
        else $error("digram popped but not loaded");

    a_first_unflagged: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && sec_valid_reg) |-> (!m_beat_reg.run_last && !m_beat_reg.msg_end))
        else $error("first letter of a digram carries end flags");

endmodule

// ===== sv/playfair_digram_cipher.sv =====
// top level of the playfair digram cipher with configuration registers
//
// Input stream: one letter code per beat on s_tdata, s_tlast on the final
// letter of a message. Output stream: one transformed letter per beat on
// m_tdata, m_tuser high on the last letter caused by an input beat, m_tlast
// high on the final letter of the message.
// The front end pairs letters, splits doubled letters and pads an odd final
// letter with x; digrams pass through a two-entry queue to the back end,
// which looks up the 5x5 square and shows two letters, one beat a cycle
// while m_tready is high. A digram goes through the queue into the output
// register, its second letter held in a second register; the next digram
// is popped once that letter moves on. A doubled final letter makes two
// digrams and holds s_tready low until the second digram enters the queue,
// longer if the queue is full. When the receiver stalls, the output holds
// and the queue fills; s_tready drops once the queue is full. Reset clears
// the held letter, the queue and the output, and sets all configuration
// registers to zero. Configuration is written with cfg_we, cfg_index and
// cfg_wdata; the user must do so only while idle, the block does not check.
module playfair_digram_cipher (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pfc_pkg::DATA_W-1:0]  s_tdata,   // [4:0] in_letter
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pfc_pkg::DATA_W-1:0]  m_tdata,   // [4:0] out_letter
    output logic                        m_tuser,   // [0] run_last
    output logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [pfc_pkg::CFG_W-1:0]   cfg_wdata
);
    import pfc_pkg::*;

    logic                   direction_reg;
    logic [CFG_W-1:0]       cells_low_reg;
    logic [CFG_W-1:0]       cells_mid_reg;
    letter_t                cell_last_reg;
    cfg_t                   cfg;

    logic     push, q_full, q_pop, q_valid, m_valid;
    digram_t  push_data, q_data;
    beat_t    m_beat;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
            cells_low_reg <= '0;
            cells_mid_reg <= '0;
            cell_last_reg <= '0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_DIRECTION: direction_reg <= cfg_wdata[0];
                REG_CELLS_LOW: cells_low_reg <= cfg_wdata;
                REG_CELLS_MID: cells_mid_reg <= cfg_wdata;
                REG_CELL_LAST: cell_last_reg <= cfg_wdata[LETTER_W-1:0];
                default:       direction_reg <= direction_reg;
            endcase
        end
    end

    // unpack the key square
    always_comb begin
        cfg.direction = direction_reg;
        for (int k = 0; k < LOW_CELLS; k++) begin
            cfg.cells[k]             = cells_low_reg[k * LETTER_W +: LETTER_W];
            cfg.cells[LOW_CELLS + k] = cells_mid_reg[k * LETTER_W +: LETTER_W];
        end
        cfg.cells[CELLS-1] = cell_last_reg;
    end

    pfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_letter (s_tdata[LETTER_W-1:0]),
        .in_last   (s_tlast),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    pfc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    pfc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_tready),
        .m_beat    (m_beat)
    );

    // result beat onto the stream
    assign m_tvalid = m_valid;
    assign m_tdata  = {{(DATA_W - LETTER_W){1'b0}}, m_beat.letter};
    assign m_tuser  = m_beat.run_last;
    assign m_tlast  = m_beat.msg_end;

endmodule

// ===== tb/sv/playfair_digram_cipher_chk.sv =====
`timescale 1ns / 100ps
// stream checker for the playfair digram cipher: tracks config, predicts and compares letters
module playfair_digram_cipher_chk (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [pfc_pkg::DATA_W-1:0]  s_tdata,    // [4:0] in_letter
    input  logic                        s_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [pfc_pkg::DATA_W-1:0]  m_tdata,    // [4:0] out_letter
    input  logic                        m_tuser,    // [0] run_last
    input  logic                        m_tlast,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [pfc_pkg::CFG_W-1:0]   cfg_wdata,
    output int                          n_fail,
    output int                          n_pending
);
    import pfc_pkg::*;

    typedef struct {
        letter_t letter;
        logic    run_last;
        logic    msg_end;
    } cipher_letter_t;

    // shadow copy of the configuration registers
    logic               decrypt_q;
    logic [CFG_W-1:0]   cells_lo_q;
    logic [CFG_W-1:0]   cells_mid_q;
    letter_t            cell_last_q;
    letter_t            square_q [CELLS];

    // pairing state
    letter_t            held_q;
    logic               held_ok;

    cipher_letter_t     due_letters [$];

    function automatic void rebuild_square();
        for (int k = 0; k < 12; k++) begin
            square_q[k]      = cells_lo_q[5 * k +: 5];
            square_q[12 + k] = cells_mid_q[5 * k +: 5];
        end
        square_q[24] = cell_last_q;
    endfunction

    // first cell holding the letter, cell 0 when it is nowhere
    function automatic int cell_of(input letter_t l);
        for (int k = 0; k < CELLS; k++) begin
            if (square_q[k] == l) return k;
        end
        return 0;
    endfunction

    // wrapping move along a row or column
    function automatic int shift_pos(input int p);
        if (decrypt_q) return (p == 0) ? SIDE - 1 : p - 1;
        return (p == SIDE - 1) ? 0 : p + 1;
    endfunction

    // both cipher letters of one digram, first letter in the upper half
    function automatic logic [9:0] pair_cipher(input letter_t a, input letter_t b);
        int ka;
        int kb;
        int r1;
        int c1;
        int r2;
        int c2;
        int t;
        ka = cell_of((a == FOLD_FROM) ? FOLD_TO : a);
        kb = cell_of((b == FOLD_FROM) ? FOLD_TO : b);
        r1 = ka / SIDE;
        c1 = ka % SIDE;
        r2 = kb / SIDE;
        c2 = kb % SIDE;
        if (r1 == r2) begin
            c1 = shift_pos(c1);
            c2 = shift_pos(c2);
        end else if (c1 == c2) begin
            r1 = shift_pos(r1);
            r2 = shift_pos(r2);
        end else begin
            t  = c1;
            c1 = c2;
            c2 = t;
        end
        return {square_q[r1 * SIDE + c1], square_q[r2 * SIDE + c2]};
    endfunction

    // pair up one incoming letter and queue the cipher letters it releases
    task automatic advance_pairing(input letter_t l, input logic fin);
        letter_t        outs [$];
        logic [9:0]     pr;
        cipher_letter_t item;
        if (held_ok) begin
            if (held_q != l) begin
                pr = pair_cipher(held_q, l);
                held_ok = 1'b0;
            end else begin
                // doubled letter: pad the held one, keep the new one waiting
                pr = pair_cipher(held_q, PAD_CODE);
                held_q = l;
            end
            outs.insert(outs.size(), pr[9:5]);
            outs.insert(outs.size(), pr[4:0]);
        end else begin
            held_q  = l;
            held_ok = 1'b1;
        end
        // end of message flushes a waiting letter with the pad
        if (fin && held_ok) begin
            pr = pair_cipher(held_q, PAD_CODE);
            outs.insert(outs.size(), pr[9:5]);
            outs.insert(outs.size(), pr[4:0]);
            held_ok = 1'b0;
        end
        foreach (outs[i]) begin
            item.letter   = outs[i];
            item.run_last = (i == outs.size() - 1);
            item.msg_end  = fin && (i == outs.size() - 1);
            due_letters.insert(due_letters.size(), item);
        end
    endtask

    task automatic check_beat();
        cipher_letter_t want;
        if (due_letters.size() == 0) begin
            $error("result beat with no letter expected: out_letter %0d", m_tdata);
            n_fail++;
        end else begin
            want = due_letters.pop_front();
            if (m_tdata !== DATA_W'(want.letter)) begin
                $error("out_letter: expected %0d, got %0d", want.letter, m_tdata);
                n_fail++;
            end
            if (m_tuser !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, m_tuser);
                n_fail++;
            end
            if (m_tlast !== want.msg_end) begin
                $error("message_end: expected %0b, got %0b", want.msg_end, m_tlast);
                n_fail++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_q   = 1'b0;
            cells_lo_q  = '0;
            cells_mid_q = '0;
            cell_last_q = '0;
            rebuild_square();
            held_q      = '0;
            held_ok     = 1'b0;
            n_fail      = 0;
            due_letters.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_DIRECTION: decrypt_q   = cfg_wdata[0];
                    REG_CELLS_LOW: cells_lo_q  = cfg_wdata;
                    REG_CELLS_MID: cells_mid_q = cfg_wdata;
                    REG_CELL_LAST: cell_last_q = cfg_wdata[LETTER_W-1:0];
                    default: ;
                endcase
                rebuild_square();
            end
            if (s_tvalid && s_tready) begin
                advance_pairing(s_tdata[LETTER_W-1:0], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_beat();
            end
        end
        n_pending = due_letters.size();
    end

endmodule

// ===== tb/sv/playfair_digram_cipher_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the playfair digram cipher: clock, reset, stimulus and verdict
module playfair_digram_cipher_tb;
    import pfc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LETTER_X    = 23;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata   = '0;    // [4:0] in_letter
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [DATA_W-1:0]   m_tdata;           // [4:0] out_letter
    logic                m_tuser;           // [0] run_last
    logic                m_tlast;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    int                  n_fail;
    int                  n_pending;
    int                  quiet_cycles = 0;
    logic                tx_gaps = 1'b1;
    logic                rx_gaps = 1'b1;
    letter_t             plain_square [CELLS];

    playfair_digram_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    playfair_digram_cipher_chk chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .n_fail    (n_fail),
        .n_pending (n_pending)
    );

    always #5 aclk = ~aclk;

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall before each beat
    initial begin : letter_sink
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = rx_gaps ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // one input beat with a random gap in front
    task automatic send_letter(input letter_t l, input logic fin);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(l);
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // wait until every expected letter is out, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_square(input logic dir, input logic [CFG_W-1:0] lo,
                               input logic [CFG_W-1:0] mid, input letter_t lst);
        write_reg(REG_DIRECTION, CFG_W'(dir));
        write_reg(REG_CELLS_LOW, lo);
        write_reg(REG_CELLS_MID, mid);
        write_reg(REG_CELL_LAST, CFG_W'(lst));
        cfg_we <= 1'b0;
    endtask

    // pack a square: bits 59:0 low cells, 119:60 mid cells, 124:120 last cell
    function automatic logic [124:0] pack_square(input letter_t sq [CELLS]);
        logic [124:0] w;
        for (int k = 0; k < CELLS; k++) begin
            w[5 * k +: 5] = sq[k];
        end
        return w;
    endfunction

    task automatic load_letters(input logic dir, input letter_t sq [CELLS]);
        logic [124:0] w;
        w = pack_square(sq);
        load_square(dir, w[59:0], w[119:60], w[124:120]);
    endtask

    // 25 letters without j in random order
    task automatic shuffle_square(output letter_t sq [CELLS]);
        int      j;
        letter_t t;
        for (int k = 0; k < CELLS; k++) sq[k] = letter_t'((k < 9) ? k : k + 1);
        for (int k = CELLS - 1; k > 0; k--) begin
            j     = $urandom_range(0, k);
            t     = sq[k];
            sq[k] = sq[j];
            sq[j] = t;
        end
    endtask

    // random messages, biased toward doubled letters, pads and the i/j pair
    task automatic run_messages(input int count);
        int      sent;
        int      len;
        int      pick;
        letter_t l;
        letter_t prev;
        sent = 0;
        prev = '0;
        while (sent < count) begin
            len     = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(0, 9);
                if (pick < 2 && i > 0)  l = prev;
                else if (pick == 2)     l = letter_t'(LETTER_X);
                else if (pick == 3)     l = $urandom_range(0, 1) ? FOLD_FROM : FOLD_TO;
                else                    l = letter_t'($urandom_range(0, 25));
                send_letter(l, i == len - 1);
                prev = l;
            end
            sent += len;
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        settle();
    endtask

    initial begin : stimulus
        // letter plus 32 for the end of a message
        int      directed_seq [] = '{7, 4, 11, 11, 14 + 32,   // doubled l, odd end
                                     0, 1, 4, 0,              // row rule, row wrap
                                     0, 5, 21, 0,             // column rule, column wrap
                                     0, 6,                    // rectangle
                                     9, 8,                    // j folds onto i
                                     23, 23 + 32,             // pad meets pad, four letters
                                     2, 2 + 32,               // doubled final letter
                                     23 + 32,                 // lone final x
                                     25, 24 + 32};
        letter_t sq [CELLS];
        logic    [CFG_W-1:0] lo;
        logic    [CFG_W-1:0] mid;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers still at their reset value: everything maps to cell 0
        run_messages(30);

        // directed pass through the textbook square
        for (int k = 0; k < CELLS; k++) plain_square[k] = letter_t'((k < 9) ? k : k + 1);
        load_letters(1'b0, plain_square);
        foreach (directed_seq[i]) begin
            send_letter(letter_t'(directed_seq[i] % 32), directed_seq[i] >= 32);
        end
        settle();

        load_letters(1'b1, plain_square);
        run_messages(60);

        shuffle_square(sq);
        load_letters(1'b0, sq);
        run_messages(60);

        shuffle_square(sq);
        load_letters(1'b1, sq);
        run_messages(60);

        // arbitrary cell codes: repeats, missing letters, codes above z
        lo  = CFG_W'({$urandom, $urandom});
        mid = CFG_W'({$urandom, $urandom});
        load_square(1'($urandom_range(0, 1)), lo, mid, letter_t'($urandom_range(0, 31)));
        run_messages(60);

        // all ones and all zeros
        load_square(1'b1, '1, '1, '1);
        run_messages(40);
        load_square(1'b0, '0, '0, '0);
        run_messages(30);

        shuffle_square(sq);
        load_letters(1'b0, sq);
        run_messages(60);

        if (n_fail == 0 && n_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
